FILE: sv/qlsf_pkg.sv
// Shared types, codes and defaults of the quadratic least-squares fit core.
`default_nettype none
package qlsf_pkg;

	localparam int DEF_MAX_POINTS = 1024;
	localparam int DEF_COORD_BITS = 10;
	localparam int DEF_FRAC_BITS  = 16;

	// Width of a coordinate field on the point channel.
	localparam int COORD_FIELD_BITS = 10;
	localparam int COEF_BITS        = 32;

	localparam logic [1:0] FIT_OK       = 2'd0;
	localparam logic [1:0] FIT_SINGULAR = 2'd1;
	localparam logic [1:0] FIT_OVERFLOW = 2'd2;

	localparam logic [COEF_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [COEF_BITS-1:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic [COORD_FIELD_BITS-1:0] abscissa;
		logic [COORD_FIELD_BITS-1:0] ordinate;
		logic                        last_point;
	} point_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] coef_const;
		logic signed [COEF_BITS-1:0] coef_linear;
		logic signed [COEF_BITS-1:0] coef_square;
		logic [1:0]                  fit_status;
	} fit_t;

endpackage
`default_nettype wire

FILE: sv/qlsf_accum.sv
// Front end: point pipeline that forms powers and accumulates the run sums.
`default_nettype none
module qlsf_accum #(
	parameter int MAX_POINTS = qlsf_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = qlsf_pkg::DEF_COORD_BITS,
	parameter int JOB_BITS   = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             point_valid,
	output logic                  point_ready,
	input  wire qlsf_pkg::point_t point,
	output logic                  job_push,
	input  wire logic             job_full,
	output logic [JOB_BITS-1:0]   job
);
	import qlsf_pkg::*;

	localparam int XB = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS : COORD_FIELD_BITS;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = 4 * XB + CW;
	localparam int MW = 3 * XB + CW;

	logic          adv, take, in_range;
	logic          v_s1, v_s2, last_s1, last_s2;
	logic [XB-1:0] x_s1, y_s1, x_s2, y_s2;
	logic [2*XB-1:0] x2_s1, xy_s1, x2_s2, xy_s2;
	logic [3*XB-1:0] x3_s2, x2y_s2;
	logic [4*XB-1:0] x4_s2;

	logic [CW-1:0] cnt_q, cnt_n;
	logic          ovf_q, ovf_n;
	logic [PW-1:0] p1_q, p2_q, p3_q, p4_q, p1_n, p2_n, p3_n, p4_n;
	logic [MW-1:0] m0_q, m1_q, m2_q, m0_n, m1_n, m2_n;

	// The whole pipeline holds only when a finished run cannot enter the queue.
	assign adv         = !(v_s2 && last_s2 && job_full);
	assign point_ready = adv;
	assign take        = v_s2 && adv;
	assign in_range    = cnt_q < CW'(MAX_POINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= point_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= point.abscissa[XB-1:0];
			y_s1    <= point.ordinate[XB-1:0];
			x2_s1   <= point.abscissa[XB-1:0] * point.abscissa[XB-1:0];
			xy_s1   <= point.abscissa[XB-1:0] * point.ordinate[XB-1:0];
			last_s1 <= point.last_point;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			x2_s2   <= x2_s1;
			xy_s2   <= xy_s1;
			x3_s2   <= x2_s1 * x_s1;
			x4_s2   <= x2_s1 * x2_s1;
			x2y_s2  <= xy_s1 * x_s1;
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		cnt_n = cnt_q;
		ovf_n = ovf_q;
		p1_n  = p1_q;
		p2_n  = p2_q;
		p3_n  = p3_q;
		p4_n  = p4_q;
		m0_n  = m0_q;
		m1_n  = m1_q;
		m2_n  = m2_q;
		if (in_range) begin
			cnt_n = cnt_q + CW'(1);
			p1_n  = p1_q + PW'(x_s2);
			p2_n  = p2_q + PW'(x2_s2);
			p3_n  = p3_q + PW'(x3_s2);
			p4_n  = p4_q + PW'(x4_s2);
			m0_n  = m0_q + MW'(y_s2);
			m1_n  = m1_q + MW'(xy_s2);
			m2_n  = m2_q + MW'(x2y_s2);
		end else begin
			ovf_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			p1_q  <= '0;
			p2_q  <= '0;
			p3_q  <= '0;
			p4_q  <= '0;
			m0_q  <= '0;
			m1_q  <= '0;
			m2_q  <= '0;
		end else if (take) begin
			if (last_s2) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				p1_q  <= '0;
				p2_q  <= '0;
				p3_q  <= '0;
				p4_q  <= '0;
				m0_q  <= '0;
				m1_q  <= '0;
				m2_q  <= '0;
			end else begin
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
				p1_q  <= p1_n;
				p2_q  <= p2_n;
				p3_q  <= p3_n;
				p4_q  <= p4_n;
				m0_q  <= m0_n;
				m1_q  <= m1_n;
				m2_q  <= m2_n;
			end
		end
	end

	assign job_push = take && last_s2;
	assign job      = {ovf_n, cnt_n, p4_n, p3_n, p2_n, p1_n, m2_n, m1_n, m0_n};

endmodule
`default_nettype wire

FILE: sv/qlsf_queue.sv
// Two-entry queue of finished run sums between the front and back ends.
`default_nettype none
module qlsf_queue #(
	parameter int WIDTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      rdata
);
	import qlsf_pkg::*;

	logic [WIDTH-1:0] mem [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full  = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign rdata = mem[rd_ptr_q];

endmodule
`default_nettype wire

FILE: sv/qlsf_solver.sv
// Back end: Cramer solve with a serial multiplier and a restoring divider.
`default_nettype none
module qlsf_solver #(
	parameter int MAX_POINTS = qlsf_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = qlsf_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = qlsf_pkg::DEF_FRAC_BITS,
	parameter int JOB_BITS   = 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                job_valid,
	output logic                     job_pop,
	input  wire logic [JOB_BITS-1:0] job,
	output logic                     fit_valid,
	input  wire logic                fit_ready,
	output qlsf_pkg::fit_t           fit
);
	import qlsf_pkg::*;

	localparam int XB  = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS : COORD_FIELD_BITS;
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int PW  = 4 * XB + CW;
	localparam int MW  = 3 * XB + CW;
	localparam int EW  = PW;
	localparam int W   = 3 * EW + FRAC_BITS + 4;
	localparam int MCW = $clog2(EW);
	localparam int DCW = $clog2(W);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MULI = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_ACC  = 4'd3;
	localparam logic [3:0] S_DET  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_RND  = 4'd6;
	localparam logic [3:0] S_SAT  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	localparam logic [1:0] K_DET  = 2'd3;
	localparam logic [3:0] STEP_LAST = 4'd8;

	logic [3:0]     state_q, step_q;
	logic [1:0]     k_q;
	logic [MCW-1:0] mcnt_q;
	logic [DCW-1:0] dcnt_q;
	logic           fit_valid_q;

	logic [CW-1:0]  cnt_j;
	logic [PW-1:0]  psum_j [4];
	logic [MW-1:0]  mom_j  [3];
	logic [EW-1:0]  sel    [5];
	logic [EW-1:0]  mat    [3][3];

	logic [W-1:0]   mcand_q, prod_q, t_q, d_q, det_q, den_q, rem_q, quo_q;
	logic [EW-1:0]  mplier_q;
	logic           neg_q;
	logic [COEF_BITS-1:0] coef_q [3];
	logic [1:0]     status_q;
	fit_t           fit_q;

	logic [1:0]     ar, ac, br, bc;
	logic           a_is_t;
	logic [W-1:0]   op_a, abs_d, abs_det, rem_sh, rem_nx, quo_nx;
	logic           ge;
	logic           hi_nz;
	logic [COEF_BITS-1:0] sat_val;

	// Sums of the run, straight from the queue head; latched when popped.
	logic           job_ovf;
	logic [CW-1:0]  job_cnt;
	logic [PW-1:0]  job_p [4];
	logic [MW-1:0]  job_m [3];

	assign {job_ovf, job_cnt, job_p[3], job_p[2], job_p[1], job_p[0],
		job_m[2], job_m[1], job_m[0]} = job;

	assign job_pop = (state_q == S_IDLE) && job_valid;

	// Normal matrix entry (r, c) is the power sum of order r + c; column k
	// is replaced by the moment sums when forming a Cramer numerator.
	always_comb begin
		sel[0] = EW'(cnt_j);
		for (int i = 0; i < 4; i++) begin
			sel[i+1] = psum_j[i];
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mat[r][c] = (k_q == 2'(c)) ? EW'(mom_j[r]) : sel[r+c];
			end
		end
	end

	// Determinant by cofactors of row 0, one product per step.
	always_comb begin
		a_is_t = 1'b0;
		ar = 2'd1; ac = 2'd1; br = 2'd2; bc = 2'd2;
		case (step_q)
			4'd0: begin ar = 2'd1; ac = 2'd1; br = 2'd2; bc = 2'd2; end
			4'd1: begin ar = 2'd1; ac = 2'd2; br = 2'd2; bc = 2'd1; end
			4'd2: begin a_is_t = 1'b1; br = 2'd0; bc = 2'd0; end
			4'd3: begin ar = 2'd1; ac = 2'd0; br = 2'd2; bc = 2'd2; end
			4'd4: begin ar = 2'd1; ac = 2'd2; br = 2'd2; bc = 2'd0; end
			4'd5: begin a_is_t = 1'b1; br = 2'd0; bc = 2'd1; end
			4'd6: begin ar = 2'd1; ac = 2'd0; br = 2'd2; bc = 2'd1; end
			4'd7: begin ar = 2'd1; ac = 2'd1; br = 2'd2; bc = 2'd0; end
			4'd8: begin a_is_t = 1'b1; br = 2'd0; bc = 2'd2; end
			default: begin a_is_t = 1'b0; end
		endcase
	end

	assign op_a    = a_is_t ? t_q : W'(mat[ar][ac]);
	assign abs_d   = d_q[W-1] ? (~d_q + W'(1)) : d_q;
	assign abs_det = det_q[W-1] ? (~det_q + W'(1)) : det_q;
	assign rem_sh  = {rem_q[W-2:0], quo_q[W-1]};
	assign ge      = rem_sh >= den_q;
	assign rem_nx  = ge ? (rem_sh - den_q) : rem_sh;
	assign quo_nx  = {quo_q[W-2:0], ge};
	assign hi_nz   = |quo_q[W-1:COEF_BITS-1];

	always_comb begin
		if (neg_q) begin
			sat_val = hi_nz ? SAT_NEG : (~quo_q[COEF_BITS-1:0] + COEF_BITS'(1));
		end else begin
			sat_val = hi_nz ? SAT_POS : quo_q[COEF_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= 4'd0;
			k_q         <= K_DET;
			mcnt_q      <= '0;
			dcnt_q      <= '0;
			fit_valid_q <= 1'b0;
		end else begin
			if (fit_valid_q && fit_ready) begin
				fit_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						k_q    <= K_DET;
						step_q <= 4'd0;
						state_q <= job_ovf ? S_OUT : S_MULI;
					end
				end
				S_MULI: begin
					mcnt_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + MCW'(1);
					if (mcnt_q == MCW'(EW - 1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (step_q == STEP_LAST) begin
						state_q <= S_DET;
					end else begin
						step_q  <= step_q + 4'd1;
						state_q <= S_MULI;
					end
				end
				S_DET: begin
					dcnt_q <= '0;
					if (k_q == K_DET) begin
						if (d_q == '0) begin
							state_q <= S_OUT;
						end else begin
							k_q     <= 2'd0;
							step_q  <= 4'd0;
							state_q <= S_MULI;
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(W - 1)) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					state_q <= S_SAT;
				end
				S_SAT: begin
					if (k_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= k_q + 2'd1;
						step_q  <= 4'd0;
						state_q <= S_MULI;
					end
				end
				S_OUT: begin
					if (!fit_valid_q) begin
						fit_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					cnt_j <= job_cnt;
					for (int i = 0; i < 4; i++) begin
						psum_j[i] <= job_p[i];
					end
					for (int i = 0; i < 3; i++) begin
						mom_j[i]  <= job_m[i];
						coef_q[i] <= '0;
					end
					status_q <= job_ovf ? FIT_OVERFLOW : FIT_OK;
				end
			end
			S_MULI: begin
				mcand_q  <= op_a;
				mplier_q <= mat[br][bc];
				prod_q   <= '0;
			end
			S_MUL: begin
				prod_q   <= prod_q + (mplier_q[0] ? mcand_q : '0);
				mcand_q  <= {mcand_q[W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[EW-1:1]};
			end
			S_ACC: begin
				case (step_q)
					4'd0, 4'd3, 4'd6: t_q <= prod_q;
					4'd1, 4'd4, 4'd7: t_q <= t_q - prod_q;
					4'd2:             d_q <= prod_q;
					4'd5:             d_q <= d_q - prod_q;
					4'd8:             d_q <= d_q + prod_q;
					default:          t_q <= t_q;
				endcase
			end
			S_DET: begin
				if (k_q == K_DET) begin
					det_q <= d_q;
					if (d_q == '0) begin
						status_q <= FIT_SINGULAR;
					end
				end else begin
					neg_q <= d_q[W-1] ^ det_q[W-1];
					den_q <= abs_det;
					quo_q <= abs_d << FRAC_BITS;
					rem_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
			S_RND: begin
				if ({rem_q, 1'b0} >= {1'b0, den_q}) begin
					quo_q <= quo_q + W'(1);
				end
			end
			S_SAT: begin
				coef_q[k_q] <= sat_val;
			end
			S_OUT: begin
				if (!fit_valid_q) begin
					fit_q.coef_const  <= coef_q[0];
					fit_q.coef_linear <= coef_q[1];
					fit_q.coef_square <= coef_q[2];
					fit_q.fit_status  <= status_q;
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign fit_valid = fit_valid_q;
	assign fit       = fit_q;

	// A failed fit never carries coefficients.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid_q && (fit_q.fit_status != FIT_OK) |->
		(fit_q.coef_const == 0) && (fit_q.coef_linear == 0) && (fit_q.coef_square == 0))
		else $error("failed fit with nonzero coefficients");

	// Division only ever runs against a nonzero determinant.
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (den_q != '0))
		else $error("division by zero determinant");

	// A new result appears only out of the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fit_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

endmodule
`default_nettype wire

FILE: sv/quadratic_least_squares_fit_core.sv
// Top level of the quadratic least-squares fit core.
// Points enter one word per cycle on the point channel while the queue has
// room; each is squared and cubed in a two-stage pipeline and added to exact
// integer sums (count, sums of x..x^4, sums of y, xy, x^2y). The word marked
// last_point closes the run: its sums go into a two-entry queue and the
// accumulators clear, so the next run may stream in at once. The solver pops
// one run at a time and forms the determinant and the three Cramer numerators
// with a shift-add multiplier (nine products per determinant, on matrix
// entries of EW = 4*min(COORD_BITS, 10) + clog2(MAX_POINTS+1) bits), then
// divides with a restoring divider of width W = 3*EW + FRAC_BITS + 4 for
// each coefficient. Input still takes one point per cycle while a solve runs,
// as long as the queue has room. Each result word gives a0, a1, a2 rounded to
// nearest, ties away from zero, in signed fixed point with FRAC_BITS fraction
// bits, saturated to 32 bits, with status ok, singular (fewer than three
// distinct abscissae, coefficients zero) or overflow (more than MAX_POINTS
// points, coefficients zero).
`default_nettype none
module quadratic_least_squares_fit_core #(
	parameter int MAX_POINTS = qlsf_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = qlsf_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = qlsf_pkg::DEF_FRAC_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             point_valid,
	output logic                  point_ready,
	input  wire qlsf_pkg::point_t point,
	output logic                  fit_valid,
	input  wire logic             fit_ready,
	output qlsf_pkg::fit_t        fit
);
	import qlsf_pkg::*;

	localparam int XB = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS : COORD_FIELD_BITS;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = 4 * XB + CW;
	localparam int MW = 3 * XB + CW;
	// One queued run: overflow flag, count, four power sums, three moments.
	localparam int JW = 1 + CW + 4 * PW + 3 * MW;

	logic          job_push, job_full, job_pop, job_valid;
	logic [JW-1:0] job_in, job_out;

	qlsf_accum #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS),
		.JOB_BITS  (JW)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point      (point),
		.job_push   (job_push),
		.job_full   (job_full),
		.job        (job_in)
	);

	qlsf_queue #(
		.WIDTH(JW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.valid (job_valid),
		.rdata (job_out)
	);

	qlsf_solver #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.JOB_BITS  (JW)
	) u_solver (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job_out),
		.fit_valid(fit_valid),
		.fit_ready(fit_ready),
		.fit      (fit)
	);

endmodule
`default_nettype wire
